[rtl/rational_newton_square_root_macros.svh]
// Assertion macros for the RTL file that checks itself.
`ifndef RATIONAL_NEWTON_SQUARE_ROOT_MACROS_SVH
`define RATIONAL_NEWTON_SQUARE_ROOT_MACROS_SVH

// Check a consequence in the same cycle as its trigger.
`define RNSR_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rnsr: same-cycle check failed");

// Check a consequence in the cycle after its trigger.
`define RNSR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rnsr: next-cycle check failed");

`endif

[rtl/rnsr_pkg.sv]
package rnsr_pkg;

	// Working word of the Newton steps and the half used by the multiplier
	localparam int WORD_W = 64;
	localparam int HALF_W = 32;

	// Factor of the final doubling of the denominator
	localparam logic [WORD_W-1:0] DBL_FACTOR = 64'd2;

	// Sequencer states
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_GCD   = 7'b0000010,
		S_RED_N = 7'b0000100,
		S_RED_D = 7'b0001000,
		S_MUL   = 7'b0010000,
		S_ADD   = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	// Multiplications of one Newton step, in issue order
	typedef enum logic [2:0] {
		OP_FDKN = 3'd0,
		OP_T1   = 3'd1,
		OP_FNKD = 3'd2,
		OP_T2   = 3'd3,
		OP_DEN  = 3'd4,
		OP_DBL  = 3'd5
	} mul_op_t;

	// Handshake between the sequencer and a multi-cycle unit
	typedef struct packed {
		logic start;
	} unit_req_t;

	typedef struct packed {
		logic done;
	} unit_rsp_t;

endpackage

[rtl/rational_newton_square_root.sv]
// Rational Heron square root. Raise start with a fraction n/d while busy is
// low; the block reduces it by its gcd, then runs STEPS Newton steps from 1/1
// on unreduced fractions and shows the final numerator, denominator and the
// overflow flag (set if any product or sum passed 64 bits) for exactly one
// cycle with done high. The receiver cannot stall, so capture the result in
// that cycle. The gcd takes E Euclid remainder steps (at most about 24 for
// 16-bit inputs), each using the bit-serial divider, and the reduction
// divides both inputs by it; when both inputs are zero the reduction is
// skipped. Then come the STEPS Newton steps, which issue six 64-bit
// products each through one multiplier that takes four 32x32 partial
// products, with the numerator sum between the fourth and fifth product,
// and finally the done cycle. busy stays high for the whole item, including
// the done cycle.
`include "rational_newton_square_root_macros.svh"

module rational_newton_square_root
	import rnsr_pkg::*;
#(
	parameter int STEPS    = 4,
	parameter int IN_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [IN_WIDTH-1:0] in_numerator,
	input  logic [IN_WIDTH-1:0] in_denominator,
	output logic                done,
	output logic [WORD_W-1:0]   root_numerator,
	output logic [WORD_W-1:0]   root_denominator,
	output logic                overflowed
);

	localparam int SW = (STEPS > 1) ? $clog2(STEPS) : 1;

	state_t              state_q;
	mul_op_t             op_q;
	logic [SW-1:0]       step_q;
	logic                launch_q;
	logic [IN_WIDTH-1:0] fn_q;
	logic [IN_WIDTH-1:0] fd_q;
	logic [IN_WIDTH-1:0] a_q;
	logic [IN_WIDTH-1:0] b_q;
	logic [WORD_W-1:0]   kn_q;
	logic [WORD_W-1:0]   kd_q;
	logic [WORD_W-1:0]   fdkn_q;
	logic [WORD_W-1:0]   t1_q;
	logic [WORD_W-1:0]   tmp_q;
	logic                ovf_q;

	unit_req_t           div_req;
	unit_rsp_t           div_rsp;
	logic [IN_WIDTH-1:0] div_dividend;
	logic [IN_WIDTH-1:0] div_quo;
	logic [IN_WIDTH-1:0] div_rem;

	unit_req_t           mul_req;
	unit_rsp_t           mul_rsp;
	logic [WORD_W-1:0]   mul_a;
	logic [WORD_W-1:0]   mul_b;
	logic [WORD_W-1:0]   mul_prod;
	logic                mul_ovf;

	logic [WORD_W-1:0]   fn_ext;
	logic [WORD_W-1:0]   fd_ext;
	logic [WORD_W:0]     sum;

	assign fn_ext = {{(WORD_W-IN_WIDTH){1'b0}}, fn_q};
	assign fd_ext = {{(WORD_W-IN_WIDTH){1'b0}}, fd_q};
	assign sum    = {1'b0, t1_q} + {1'b0, tmp_q};

	// Launch the divider: Euclid remainder a % b, then n / g and d / g
	always_comb begin
		div_req.start = launch_q &&
			((state_q == S_GCD && b_q != '0) || state_q == S_RED_N || state_q == S_RED_D);
		case (state_q)
			S_RED_N: div_dividend = fn_q;
			S_RED_D: div_dividend = fd_q;
			default: div_dividend = a_q;
		endcase
	end

	rnsr_div #(
		.W(IN_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.divisor  ((state_q == S_GCD) ? b_q : a_q),
		.rsp      (div_rsp),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	// Select the operands of the current Newton product
	always_comb begin
		mul_req.start = launch_q && (state_q == S_MUL);
		case (op_q)
			OP_FDKN: begin
				mul_a = fd_ext;
				mul_b = kn_q;
			end
			OP_T1: begin
				mul_a = kn_q;
				mul_b = fdkn_q;
			end
			OP_FNKD: begin
				mul_a = fn_ext;
				mul_b = kd_q;
			end
			OP_T2: begin
				mul_a = tmp_q;
				mul_b = kd_q;
			end
			OP_DEN: begin
				mul_a = kd_q;
				mul_b = fdkn_q;
			end
			OP_DBL: begin
				mul_a = tmp_q;
				mul_b = DBL_FACTOR;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	rnsr_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mul_req),
		.a       (mul_a),
		.b       (mul_b),
		.rsp     (mul_rsp),
		.product (mul_prod),
		.overflow(mul_ovf)
	);

	// Sequence the gcd, the reduction and the Newton steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			launch_q <= 1'b0;
			op_q     <= OP_FDKN;
			step_q   <= '0;
			fn_q     <= '0;
			fd_q     <= '0;
			a_q      <= '0;
			b_q      <= '0;
			kn_q     <= '0;
			kd_q     <= '0;
			fdkn_q   <= '0;
			t1_q     <= '0;
			tmp_q    <= '0;
			ovf_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						fn_q     <= in_numerator;
						fd_q     <= in_denominator;
						a_q      <= in_denominator;
						b_q      <= in_numerator;
						kn_q     <= WORD_W'(1);
						kd_q     <= WORD_W'(1);
						ovf_q    <= 1'b0;
						step_q   <= '0;
						op_q     <= OP_FDKN;
						launch_q <= 1'b1;
						state_q  <= S_GCD;
					end
				end
				S_GCD: begin
					if (launch_q) begin
						// zero remainder ends Euclid: a holds the gcd
						if (b_q == '0) begin
							state_q <= (a_q == '0) ? S_MUL : S_RED_N;
						end else begin
							launch_q <= 1'b0;
						end
					end else if (div_rsp.done) begin
						a_q      <= b_q;
						b_q      <= div_rem;
						launch_q <= 1'b1;
					end
				end
				S_RED_N: begin
					if (launch_q) begin
						launch_q <= 1'b0;
					end else if (div_rsp.done) begin
						fn_q     <= div_quo;
						launch_q <= 1'b1;
						state_q  <= S_RED_D;
					end
				end
				S_RED_D: begin
					if (launch_q) begin
						launch_q <= 1'b0;
					end else if (div_rsp.done) begin
						fd_q     <= div_quo;
						launch_q <= 1'b1;
						state_q  <= S_MUL;
					end
				end
				S_MUL: begin
					if (launch_q) begin
						launch_q <= 1'b0;
					end else if (mul_rsp.done) begin
						ovf_q <= ovf_q | mul_ovf;
						case (op_q)
							OP_FDKN: begin
								fdkn_q   <= mul_prod;
								op_q     <= OP_T1;
								launch_q <= 1'b1;
							end
							OP_T1: begin
								t1_q     <= mul_prod;
								op_q     <= OP_FNKD;
								launch_q <= 1'b1;
							end
							OP_FNKD: begin
								tmp_q    <= mul_prod;
								op_q     <= OP_T2;
								launch_q <= 1'b1;
							end
							OP_T2: begin
								tmp_q   <= mul_prod;
								state_q <= S_ADD;
							end
							OP_DEN: begin
								tmp_q    <= mul_prod;
								op_q     <= OP_DBL;
								launch_q <= 1'b1;
							end
							OP_DBL: begin
								kn_q <= t1_q;
								kd_q <= mul_prod;
								if (step_q == SW'(STEPS - 1)) begin
									state_q <= S_DONE;
								end else begin
									step_q   <= step_q + SW'(1);
									op_q     <= OP_FDKN;
									launch_q <= 1'b1;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_ADD: begin
					// form the new numerator and note a carry out
					t1_q     <= sum[WORD_W-1:0];
					ovf_q    <= ovf_q | sum[WORD_W];
					op_q     <= OP_DEN;
					launch_q <= 1'b1;
					state_q  <= S_MUL;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q  <= S_IDLE;
					launch_q <= 1'b0;
				end
			endcase
		end
	end

	assign busy             = (state_q != S_IDLE);
	assign done             = (state_q == S_DONE);
	assign root_numerator   = kn_q;
	assign root_denominator = kd_q;
	assign overflowed       = ovf_q;

	// Result strobe lasts one cycle, an accepted item makes the block busy,
	// the numerator sum is always followed by the denominator products, and
	// the two units are never launched together
	`RNSR_ASSERT_NEXT(a_done_single, done, !done)
	`RNSR_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)
	`RNSR_ASSERT_NEXT(a_add_then_mul, state_q == S_ADD, state_q == S_MUL && op_q == OP_DEN)
	`RNSR_ASSERT_SAME(a_one_unit, div_req.start, !mul_req.start)

endmodule

[rtl/rnsr_div.sv]
module rnsr_div
	import rnsr_pkg::*;
#(
	parameter int W = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  unit_req_t    req,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output unit_rsp_t    rsp,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [W:0]    shifted;
	logic          fits;
	logic [W:0]    diff;

	// One restoring step: bring down the next dividend bit, subtract if it fits
	always_comb begin
		shifted = {rem_q, quo_q[W-1]};
		diff    = shifted - {1'b0, dvs_q};
		fits    = (shifted >= {1'b0, dvs_q});
	end

	// Run one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				rem_q  <= '0;
				quo_q  <= dividend;
				dvs_q  <= divisor;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? diff[W-1:0] : shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], fits};
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done  = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

[rtl/rnsr_mul.sv]
module rnsr_mul
	import rnsr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  unit_req_t         req,
	input  logic [WORD_W-1:0] a,
	input  logic [WORD_W-1:0] b,
	output unit_rsp_t         rsp,
	output logic [WORD_W-1:0] product,
	output logic              overflow
);

	logic [WORD_W-1:0]   a_q;
	logic [WORD_W-1:0]   b_q;
	logic [WORD_W-1:0]   pp_q;
	logic [2*WORD_W-1:0] acc_q;
	logic [2:0]          cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [HALF_W-1:0]   op_a;
	logic [HALF_W-1:0]   op_b;
	logic [2*WORD_W-1:0] pp_ext;

	// Pick the halves for partial product cnt_q: lo*lo, lo*hi, hi*lo, hi*hi
	always_comb begin
		op_a = cnt_q[1] ? a_q[WORD_W-1:HALF_W] : a_q[HALF_W-1:0];
		op_b = cnt_q[0] ? b_q[WORD_W-1:HALF_W] : b_q[HALF_W-1:0];
	end

	// Align the registered partial product of the previous cycle
	always_comb begin
		case (cnt_q)
			3'd1:    pp_ext = {{WORD_W{1'b0}}, pp_q};
			3'd2,
			3'd3:    pp_ext = {{HALF_W{1'b0}}, pp_q, {HALF_W{1'b0}}};
			3'd4:    pp_ext = {pp_q, {WORD_W{1'b0}}};
			default: pp_ext = '0;
		endcase
	end

	// Form one 32x32 partial product a cycle and accumulate the one before
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
			pp_q   <= '0;
			acc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				a_q    <= a;
				b_q    <= b;
				acc_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				pp_q  <= WORD_W'(op_a) * WORD_W'(op_b);
				acc_q <= acc_q + pp_ext;
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign product  = acc_q[WORD_W-1:0];
	assign overflow = |acc_q[2*WORD_W-1:WORD_W];

endmodule
